// ===== sv/lru_pkg.sv =====
package lru_pkg;

    // configuration register and fixed result field widths
    localparam int CFG_W        = 5;
    localparam int FRAME_OUT_W  = 4;
    localparam int EVPAGE_W     = 8;
    localparam int FAULT_W      = 16;

    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(4);
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

endpackage

// ===== sv/lru_ram.sv =====
module lru_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/lru_page_replacement_top.sv =====
// lru page replacement, one request per page reference, one result strobe per request
// scan to a match or the last active frame, then rank sweep from frame 0 to the last filled frame
// a new request is taken only while idle; busy stays high until the strobe
// both sweeps go through the single read port of the frame ram, one frame per cycle
// reset: synchronous, active low; clears valid bits, fill count, fault count, frame count 4
// the result is shown for one cycle only, the receiver cannot stall it
module lru_page_replacement_top
    import lru_pkg::*;
#(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: frames in use
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    // request
    input  logic                   start,
    output logic                   busy,
    input  logic [PAGE_BITS-1:0]   i_page,
    // result
    output logic                   o_done,
    output logic                   o_hit,
    output logic [FRAME_OUT_W-1:0] o_frame_index,
    output logic                   o_evicted_valid,
    output logic [EVPAGE_W-1:0]    o_evicted_page,
    output logic [FAULT_W-1:0]     o_fault_count
);

    localparam int IDX_W  = $clog2(MAX_FRAMES);
    localparam int RANK_W = $clog2(MAX_FRAMES);
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int WORD_W = PAGE_BITS + RANK_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_cfg;
    logic [PAGE_BITS-1:0] r_page;
    logic [CNT_W-1:0]     r_n;
    logic [IDX_W-1:0]     r_addr;      // ram read address, one frame per cycle
    logic                 r_rd_ok;     // ram output holds frame r_didx
    logic [IDX_W-1:0]     r_didx;
    // running lru candidate of the scan
    logic                 r_have_best;
    logic [IDX_W-1:0]     r_best;
    logic [RANK_W-1:0]    r_best_rank;
    logic [PAGE_BITS-1:0] r_best_page;
    // decision of the scan, used by the rank sweep
    logic [IDX_W-1:0]     r_frame;
    logic [RANK_W-1:0]    r_old_rank;
    logic                 r_fill;
    logic                 r_hit;
    logic                 r_evict;
    logic [PAGE_BITS-1:0] r_ev_page;
    logic [IDX_W-1:0]     r_last;
    // frame bookkeeping
    logic [MAX_FRAMES-1:0] r_valid;
    logic [CNT_W-1:0]      r_filled;
    logic [FAULT_W-1:0]    r_faults;

    // ram word = {page, recency rank}
    logic [WORD_W-1:0]    ram_rdata;
    logic [WORD_W-1:0]    ram_wdata;
    logic                 ram_we;
    logic [PAGE_BITS-1:0] rd_page;
    logic [RANK_W-1:0]    rd_rank;

    logic [CNT_W-1:0]     act_n;
    logic                 is_match;
    logic                 is_last;
    logic                 take_new;
    logic [IDX_W-1:0]     cand_idx;
    logic [RANK_W-1:0]    cand_rank;
    logic [PAGE_BITS-1:0] cand_page;
    logic [IDX_W-1:0]     fill_idx;
    logic [IDX_W-1:0]     top_filled;

    assign busy    = (r_state != S_IDLE);
    assign rd_page = ram_rdata[RANK_W +: PAGE_BITS];
    assign rd_rank = ram_rdata[RANK_W-1:0];

    // frame count: zero acts as one, oversize clamps to the built count
    always_comb begin
        if (r_cfg == '0) begin
            act_n = CNT_W'(1);
        end else if (32'(r_cfg) > 32'(MAX_FRAMES)) begin
            act_n = CNT_W'(MAX_FRAMES);
        end else begin
            act_n = CNT_W'(r_cfg);
        end
    end

    // scan compare: one frame per cycle against the requested page
    assign is_match = r_valid[r_didx] && (rd_page == r_page);
    assign is_last  = (CNT_W'(r_didx) == (r_n - CNT_W'(1)));
    // strictly larger rank replaces, so ties keep the lowest index
    assign take_new = !r_have_best || (rd_rank > r_best_rank);

    always_comb begin
        if (take_new) begin
            cand_idx  = r_didx;
            cand_rank = rd_rank;
            cand_page = rd_page;
        end else begin
            cand_idx  = r_best;
            cand_rank = r_best_rank;
            cand_page = r_best_page;
        end
    end

    // filled frames are always the prefix 0..filled-1
    assign fill_idx   = IDX_W'(r_filled);
    assign top_filled = IDX_W'(r_filled - CNT_W'(1));

    // rank sweep: read-modify-write, target frame becomes most recent
    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = {rd_page, rd_rank + RANK_W'(1)};
        if (r_state == S_UPDATE && r_rd_ok) begin
            if (r_didx == r_frame) begin
                ram_we    = 1'b1;
                ram_wdata = {r_page, RANK_W'(0)};
            end else if (r_valid[r_didx] && (r_fill || rd_rank < r_old_rank)) begin
                ram_we = 1'b1;
            end
        end
    end

    lru_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_didx),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cfg         <= CFG_RESET;
            r_valid       <= '0;
            r_filled      <= '0;
            r_faults      <= '0;
            r_rd_ok       <= 1'b0;
            r_have_best   <= 1'b0;
            o_done        <= 1'b0;
            o_fault_count <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_page      <= i_page;
                        r_n         <= act_n;
                        r_addr      <= '0;
                        r_rd_ok     <= 1'b0;
                        r_have_best <= 1'b0;
                        r_hit       <= 1'b0;
                        r_evict     <= 1'b0;
                        r_fill      <= 1'b0;
                        r_ev_page   <= '0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_addr  <= r_addr + IDX_W'(1);
                    r_didx  <= r_addr;
                    r_rd_ok <= 1'b1;
                    if (r_rd_ok) begin
                        r_have_best <= 1'b1;
                        r_best      <= cand_idx;
                        r_best_rank <= cand_rank;
                        r_best_page <= cand_page;
                        if (is_match || is_last) begin
                            // leave the scan and start the rank sweep at frame 0
                            r_addr  <= '0;
                            r_rd_ok <= 1'b0;
                            r_state <= S_UPDATE;
                        end
                        if (is_match) begin
                            r_hit      <= 1'b1;
                            r_frame    <= r_didx;
                            r_old_rank <= rd_rank;
                            r_last     <= top_filled;
                        end else if (is_last) begin
                            // page fault
                            if (r_faults != FAULT_MAX) begin
                                r_faults <= r_faults + FAULT_W'(1);
                            end
                            if (r_filled < r_n) begin
                                // empty frame left: fill it, every valid frame ages
                                r_fill            <= 1'b1;
                                r_frame           <= fill_idx;
                                r_last            <= fill_idx;
                                r_valid[fill_idx] <= 1'b1;
                                r_filled          <= r_filled + CNT_W'(1);
                            end else begin
                                // all active frames full: replace the oldest one
                                r_evict    <= 1'b1;
                                r_frame    <= cand_idx;
                                r_old_rank <= cand_rank;
                                r_ev_page  <= cand_page;
                                r_last     <= top_filled;
                            end
                        end
                    end
                end
                S_UPDATE: begin
                    r_addr  <= r_addr + IDX_W'(1);
                    r_didx  <= r_addr;
                    r_rd_ok <= 1'b1;
                    if (r_rd_ok && r_didx == r_last) begin
                        r_rd_ok         <= 1'b0;
                        r_state         <= S_IDLE;
                        o_done          <= 1'b1;
                        o_hit           <= r_hit;
                        o_frame_index   <= FRAME_OUT_W'(32'(r_frame));
                        o_evicted_valid <= r_evict;
                        o_evicted_page  <= EVPAGE_W'(32'(r_ev_page));
                        o_fault_count   <= r_faults;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/lru_checker.sv =====
module lru_checker
    import lru_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_done,
    input logic                 o_hit,
    input logic                 o_evicted_valid,
    input logic [FAULT_W-1:0]   o_fault_count
);

    // an accepted request keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but busy not raised");

    // the result strobe closes the busy period
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // no two results back to back
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // a hit never replaces a page
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit) |-> !o_evicted_valid)
        else $error("eviction reported on a hit");

    // a fault has been counted
    a_fault_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_fault_count != '0))
        else $error("fault reported with zero fault count");

endmodule

bind lru_page_replacement_top lru_checker u_lru_checker (.*);
